// File: design/vector3_fixed_point_alu_macros.svh
// Assertion macros shared by the vector ALU modules.
`ifndef VECTOR3_FIXED_POINT_ALU_MACROS_SVH
`define VECTOR3_FIXED_POINT_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define VFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VFA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define VFA_ASSERT(lbl, prop, msg)
`define VFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: design/vfa_pkg.sv
// Types, constants and helper functions of the fixed-point vector ALU.
package vfa_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int WORD_BITS   = 32;
  localparam int DATA_W      = 32;
  localparam int SAT_BITS    = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int MAG_W       = 2 * DATA_W;
  localparam int ROOT_W      = DATA_W;
  localparam int SQ_STAGES   = ROOT_W;
  localparam int DIVD_W      = DATA_W + FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [MAG_W-1:0] MAX_POS = MAG_W'((65'd1 << (SAT_BITS - 1)) - 65'd1);
  localparam logic [MAG_W-1:0] MAX_NEG = MAG_W'(65'd1 << (SAT_BITS - 1));

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_DOT   = 4'd4,
    OP_CROSS = 4'd5,
    OP_PROD  = 4'd6,
    OP_NORM  = 4'd7,
    OP_LEN   = 4'd8,
    OP_LENSQ = 4'd9,
    OP_EQ    = 4'd10,
    OP_NOP   = 4'd11
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [2:0][DATA_W-1:0]  a;
    logic [2:0][DATA_W-1:0]  b;
    logic [DATA_W-1:0]       s;
  } item_t;

  typedef struct packed {
    op_t                     op;
    logic [2:0][DATA_W-1:0]  a;
    logic [DATA_W-1:0]       s;
    logic [2:0][DATA_W-1:0]  res;
    logic                    eq;
    logic [1:0]              st;
    logic                    rzero;
  } tok_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } fin_t;

  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? ('0 - v) : v;
  endfunction

  // Clamps a sign and magnitude to the signed result range.
  function automatic fin_t finish(input logic neg, input logic [MAG_W-1:0] mag);
    fin_t              f;
    logic [MAG_W-1:0]  m;
    logic [DATA_W-1:0] lo;
    m = mag;
    f.sat = 1'b0;
    if (!neg && mag > MAX_POS) begin
      m = MAX_POS;
      f.sat = 1'b1;
    end
    if (neg && mag > MAX_NEG) begin
      m = MAX_NEG;
      f.sat = 1'b1;
    end
    lo = m[DATA_W-1:0];
    f.val = neg ? ('0 - lo) : lo;
    return f;
  endfunction
endpackage

// File: design/vfa_front.sv
// Input stage: accepts beats and classifies the operation code.
module vfa_front import vfa_pkg::*; (
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [3:0]        op,
  input  logic [DATA_W-1:0] ax,
  input  logic [DATA_W-1:0] ay,
  input  logic [DATA_W-1:0] az,
  input  logic [DATA_W-1:0] bx,
  input  logic [DATA_W-1:0] by,
  input  logic [DATA_W-1:0] bz,
  input  logic [DATA_W-1:0] scalar,
  input  logic              q_full,
  output logic              push,
  output item_t             item
);
  op_t cls;

  always_comb begin
    unique case (op) inside
      [OP_ADD:OP_EQ]: cls = op_t'(op);
      default:        cls = OP_NOP;
    endcase
  end

  assign item_ready = !q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    item.op = cls;
    item.a  = {az, ay, ax};
    item.b  = {bz, by, bx};
    item.s  = scalar;
  end
endmodule

// File: design/vfa_queue.sv
// Short queue between the classifying front and the execution pipeline.
`include "vector3_fixed_point_alu_macros.svh"
module vfa_queue import vfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);
  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= item;
  end

  assign head  = mem[rptr];
  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));

  `VFA_ASSERT(a_no_overflow, push |-> !full, "queue written while full")
  `VFA_ASSERT(a_no_underflow, pop |-> !empty, "queue read while empty")
  `VFA_ASSERT(a_count_range, count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count out of range")
endmodule

// File: design/vfa_back.sv
// Execution pipeline: multipliers, combine, square root, divider and result register.
`include "vector3_fixed_point_alu_macros.svh"
module vfa_back import vfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             head,
  input  logic              empty,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [DATA_W-1:0] rx,
  output logic [DATA_W-1:0] ry,
  output logic [DATA_W-1:0] rz,
  output logic              is_equal,
  output logic [1:0]        status
);
  logic adv;
  assign adv = !result_valid || result_ready;
  assign pop = adv && !empty;

  // Multiplier stage.
  logic                     v1;
  item_t                    it1;
  logic signed [PROD_W-1:0] p1 [3];
  logic signed [PROD_W-1:0] p2 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= !empty;
  end

  always_ff @(posedge clk) begin
    if (adv) it1 <= head;
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [DATA_W-1:0] x1, y1, x2, y2;

    always_comb begin
      x1 = head.a[i];
      y1 = head.b[i];
      x2 = head.a[K];
      y2 = head.b[J];
      case (head.op) inside
        OP_SCALE: y1 = head.s;
        OP_CROSS: begin
          x1 = head.a[J];
          y1 = head.b[K];
        end
        OP_NORM, OP_LEN, OP_LENSQ: y1 = head.a[i];
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p1[i] <= x1 * y1;
        p2[i] <= x2 * y2;
      end
    end
  end

  // Combine stage.
  fin_t lf [3];

  for (genvar i = 0; i < 3; i++) begin : g_comb
    logic signed [DATA_W+1:0] t, tabs;
    logic signed [PROD_W-1:0] pabs;
    logic signed [PROD_W:0]   d, dabs;
    fin_t                     f;

    always_comb begin
      if (it1.op == OP_SUB) begin
        t = (DATA_W+2)'($signed(it1.a[i])) - (DATA_W+2)'($signed(it1.b[i]));
      end else begin
        t = (DATA_W+2)'($signed(it1.a[i])) + (DATA_W+2)'($signed(it1.b[i]));
      end
      tabs = t[DATA_W+1] ? -t : t;
      pabs = p1[i][PROD_W-1] ? -p1[i] : p1[i];
      d    = (PROD_W+1)'(p1[i]) - (PROD_W+1)'(p2[i]);
      dabs = d[PROD_W] ? -d : d;
      case (it1.op) inside
        OP_ADD, OP_SUB:    f = finish(t[DATA_W+1], MAG_W'(tabs));
        OP_SCALE, OP_PROD: f = finish(p1[i][PROD_W-1], MAG_W'(pabs) >> FRAC_BITS);
        OP_CROSS:          f = finish(d[PROD_W], dabs[MAG_W-1:0] >> FRAC_BITS);
        default:           f = '0;
      endcase
    end

    assign lf[i] = f;
  end

  logic signed [PROD_W+1:0] dsum, dsabs;
  logic [MAG_W-1:0]         rad;
  fin_t                     fdot, fsq;
  tok_t                     ctok;

  always_comb begin
    dsum  = (PROD_W+2)'(p1[0]) + (PROD_W+2)'(p1[1]) + (PROD_W+2)'(p1[2]);
    dsabs = dsum[PROD_W+1] ? -dsum : dsum;
    rad   = dsum[MAG_W-1:0];
    fdot  = finish(dsum[PROD_W+1], dsabs[MAG_W-1:0] >> FRAC_BITS);
    fsq   = finish(1'b0, rad >> FRAC_BITS);
    ctok  = '0;
    ctok.op = it1.op;
    ctok.a  = it1.a;
    ctok.s  = it1.s;
    ctok.st = ST_OK;
    case (it1.op) inside
      OP_ADD, OP_SUB, OP_SCALE, OP_PROD, OP_CROSS: begin
        ctok.res = {lf[2].val, lf[1].val, lf[0].val};
        if (lf[0].sat || lf[1].sat || lf[2].sat) ctok.st = ST_SAT;
      end
      OP_DOT: begin
        ctok.res[0] = fdot.val;
        if (fdot.sat) ctok.st = ST_SAT;
      end
      OP_LENSQ: begin
        ctok.res[0] = fsq.val;
        if (fsq.sat) ctok.st = ST_SAT;
      end
      OP_NORM: ctok.res = it1.a;
      OP_EQ:   ctok.eq = (it1.a == it1.b);
      default: ;
    endcase
  end

  // Square root pipeline, one root bit per stage.
  logic                sq_v    [SQ_STAGES+1];
  tok_t                sq_tok  [SQ_STAGES+1];
  logic [MAG_W-1:0]    sq_rad  [SQ_STAGES+1];
  logic [ROOT_W+1:0]   sq_rem  [SQ_STAGES+1];
  logic [ROOT_W-1:0]   sq_root [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_tok[0]  <= ctok;
      sq_rad[0]  <= rad;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [ROOT_W+1:0] cur, trial;

    assign cur   = {sq_rem[k][ROOT_W-1:0], sq_rad[k][MAG_W-1 -: 2]};
    assign trial = {sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_tok[k+1] <= sq_tok[k];
        sq_rad[k+1] <= sq_rad[k] << 2;
        if (cur >= trial) begin
          sq_rem[k+1]  <= cur - trial;
          sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= cur;
          sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Divider setup.
  logic                    dv_v   [DIVD_W+1];
  tok_t                    dv_tok [DIVD_W+1];
  logic [DATA_W-1:0]       dv_den [DIVD_W+1];
  logic [2:0][DATA_W-1:0]  dv_rem [DIVD_W+1];
  logic [2:0][DIVD_W-1:0]  dv_q   [DIVD_W+1];

  logic [ROOT_W-1:0]       root;
  tok_t                    stok;
  fin_t                    flen;
  logic [DATA_W-1:0]       sden;
  logic [2:0][DIVD_W-1:0]  sdvd;

  always_comb begin
    root       = sq_root[SQ_STAGES];
    stok       = sq_tok[SQ_STAGES];
    stok.rzero = (root == '0);
    flen       = finish(1'b0, MAG_W'(root));
    if (stok.op == OP_LEN) begin
      stok.res[0] = flen.val;
      stok.st     = flen.sat ? ST_SAT : ST_OK;
    end
    sden = (stok.op == OP_NORM) ? root : mag_of(stok.s);
    for (int l = 0; l < 3; l++) begin
      sdvd[l] = {mag_of(stok.a[l]), {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= sq_v[SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tok[0] <= stok;
      dv_den[0] <= sden;
      dv_rem[0] <= '0;
      dv_q[0]   <= sdvd;
    end
  end

  // Restoring divider, one quotient bit per stage for each lane.
  for (genvar k = 0; k < DIVD_W; k++) begin : g_div
    logic [2:0][DATA_W:0]   cur;
    logic [2:0]             ge;
    logic [2:0][DATA_W-1:0] rem_next;
    logic [2:0][DIVD_W-1:0] q_next;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cur[l]      = {dv_rem[k][l], dv_q[k][l][DIVD_W-1]};
        ge[l]       = (cur[l] >= {1'b0, dv_den[k]});
        rem_next[l] = ge[l] ? DATA_W'(cur[l] - {1'b0, dv_den[k]}) : cur[l][DATA_W-1:0];
        q_next[l]   = {dv_q[k][l][DIVD_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (adv) dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_tok[k+1] <= dv_tok[k];
        dv_den[k+1] <= dv_den[k];
        dv_rem[k+1] <= rem_next;
        dv_q[k+1]   <= q_next;
      end
    end
  end

  // Final selection.
  tok_t                   ft;
  logic [2:0][DATA_W-1:0] fres;
  logic [1:0]             fst;
  logic [2:0]             fsat;
  logic                   sneg, szero;
  logic [MAG_W-1:0]       qm;
  fin_t                   fq, fa, fz;

  always_comb begin
    ft    = dv_tok[DIVD_W];
    fres  = ft.res;
    fst   = ft.st;
    fsat  = '0;
    sneg  = ft.s[DATA_W-1];
    szero = (ft.s == '0);
    qm    = '0;
    fq    = '0;
    fa    = '0;
    fz    = '0;
    for (int l = 0; l < 3; l++) begin
      qm = MAG_W'(dv_q[DIVD_W][l]);
      fq = finish(ft.a[l][DATA_W-1] ^ sneg, qm);
      fa = finish(ft.a[l][DATA_W-1], qm);
      fz = finish(ft.a[l][DATA_W-1], '1);
      if (ft.op == OP_DIV) begin
        if (szero) begin
          fres[l] = (ft.a[l] == '0) ? '0 : fz.val;
        end else begin
          fres[l] = fq.val;
          fsat[l] = sneg ? (qm > MAX_POS) : fa.sat;
        end
      end else if (ft.op == OP_NORM && !ft.rzero) begin
        fres[l] = fa.val;
        fsat[l] = fa.sat;
      end
    end
    if (ft.op == OP_DIV && szero) fst = ST_DIV0;
    else if (|fsat) fst = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= dv_v[DIVD_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx       <= fres[0];
      ry       <= fres[1];
      rz       <= fres[2];
      is_equal <= ft.eq;
      status   <= fst;
    end
  end

  `VFA_ASSERT(a_eq_status, result_valid && is_equal |-> status == ST_OK, "equal beat with bad status")
  `VFA_ASSERT_NEXT(a_drain, dv_v[DIVD_W] && adv, result_valid, "finished item not presented")
  `VFA_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(rx), "stalled result beat changed")
endmodule

// File: design/vector3_fixed_point_alu.sv
// Top level of the signed fixed-point 3-D vector ALU.
// Takes one beat per cycle while the input queue is not full, and returns one result
// beat per input beat, in order. Every item runs the same fixed pipeline: a queue entry,
// a multiplier stage, a combine stage, a 32-stage square root (one root bit per stage),
// a setup stage, a divider of 32 + FRAC_BITS stages (48 at Q16.16, one quotient bit per
// stage) and a result register. Throughput is one item per cycle while the result is not
// stalled. A stalled result holds the whole pipeline while the four-entry input queue
// keeps taking beats until it is full.
module vector3_fixed_point_alu import vfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [3:0]               op,
  input  logic signed [DATA_W-1:0] ax,
  input  logic signed [DATA_W-1:0] ay,
  input  logic signed [DATA_W-1:0] az,
  input  logic signed [DATA_W-1:0] bx,
  input  logic signed [DATA_W-1:0] by,
  input  logic signed [DATA_W-1:0] bz,
  input  logic signed [DATA_W-1:0] scalar,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [DATA_W-1:0] rx,
  output logic signed [DATA_W-1:0] ry,
  output logic signed [DATA_W-1:0] rz,
  output logic                     is_equal,
  output logic [1:0]               status
);
  logic  push, pop, empty, full;
  item_t item, head;

  vfa_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .ax         (ax),
    .ay         (ay),
    .az         (az),
    .bx         (bx),
    .by         (by),
    .bz         (bz),
    .scalar     (scalar),
    .q_full     (full),
    .push       (push),
    .item       (item)
  );

  vfa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  vfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .rx           (rx),
    .ry           (ry),
    .rz           (rz),
    .is_equal     (is_equal),
    .status       (status)
  );
endmodule

// File: test/vector3_fixed_point_alu_tb.sv
// Self-checking testbench for the fixed-point 3-D vector ALU: directed table, then random beats.
module vector3_fixed_point_alu_tb import vfa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_TOP_UNUSED = 4'd15;
  localparam int NUM_RANDOM = 580;
  localparam int QUIET_TAIL = 60;

  typedef logic signed [31:0] word_t;

  typedef struct {
    logic [3:0] op;
    word_t      a [3];
    word_t      b [3];
    word_t      s;
  } vec_item_t;

  typedef struct {
    word_t      r [3];
    logic       eq;
    logic [1:0] st;
  } vec_result_t;

  typedef struct {
    logic [3:0] op;
    word_t      a [3];
    word_t      b [3];
    word_t      s;
    bit         known;
    word_t      r [3];
    logic       eq;
    logic [1:0] st;
  } table_row_t;

  typedef struct {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  logic [3:0] op;
  word_t      ax, ay, az, bx, by, bz, scalar;
  logic       result_valid;
  logic       result_ready;
  word_t      rx, ry, rz;
  logic       is_equal;
  logic [1:0] status;

  vec_result_t expected_results [$];
  int          errors = 0;
  bit          quiet = 0;

  vector3_fixed_point_alu dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .op(op),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .scalar(scalar),
    .result_valid(result_valid), .result_ready(result_ready), .rx(rx), .ry(ry), .rz(rz),
    .is_equal(is_equal), .status(status)
  );

  // Rows with the known bit set carry expectations; the rest use the predictor.
  table_row_t directed [24] = '{
    '{OP_ADD, '{32'h7fffffff, 0, 0}, '{1, 0, 0}, 0, 1, '{32'h7fffffff, 0, 0}, 0, ST_SAT},
    '{OP_ADD, '{32'h80000000, 0, 0}, '{-1, 0, 0}, 0, 1, '{32'h80000000, 0, 0}, 0, ST_SAT},
    '{OP_SUB, '{32'h80000000, 0, 0}, '{1, 0, 0}, 0, 1, '{32'h80000000, 0, 0}, 0, ST_SAT},
    '{OP_DIV, '{1, -1, 0}, '{0, 0, 0}, 0, 1, '{32'h7fffffff, 32'h80000000, 0}, 0, ST_DIV0},
    '{OP_DIV, '{0, 0, 0}, '{5, 5, 5}, 0, 1, '{0, 0, 0}, 0, ST_DIV0},
    '{OP_NORM, '{0, 0, 0}, '{7, 7, 7}, 3, 1, '{0, 0, 0}, 0, ST_OK},
    '{OP_EQ, '{1, 2, 3}, '{1, 2, 3}, 0, 1, '{0, 0, 0}, 1, ST_OK},
    '{OP_EQ, '{1, 2, 3}, '{1, 2, 4}, 0, 1, '{0, 0, 0}, 0, ST_OK},
    '{OP_NOP, '{-1, -1, -1}, '{-1, -1, -1}, -1, 1, '{0, 0, 0}, 0, ST_OK},
    '{OP_TOP_UNUSED, '{9, 9, 9}, '{9, 9, 9}, 9, 1, '{0, 0, 0}, 0, ST_OK},
    '{OP_LEN, '{32'h10000, 0, 0}, '{0, 0, 0}, 0, 1, '{32'h10000, 0, 0}, 0, ST_OK},
    '{OP_LENSQ, '{32'h80000000, 0, 0}, '{0, 0, 0}, 0, 1, '{32'h7fffffff, 0, 0}, 0, ST_SAT},
    '{OP_SCALE, '{32'h7fffffff, 32'h80000000, 1}, '{0, 0, 0}, 32'hffff0000, 0,
      '{0, 0, 0}, 0, ST_OK},
    '{OP_SCALE, '{32'h80000000, 32'h7fffffff, -1}, '{0, 0, 0}, 32'h80000000, 0,
      '{0, 0, 0}, 0, ST_OK},
    '{OP_DIV, '{32'h80000000, 32'h7fffffff, 1}, '{0, 0, 0}, -1, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_DIV, '{32'h7fffffff, -1, 32'h10000}, '{0, 0, 0}, 1, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_DIV, '{32'h10000, 32'h80000000, 0}, '{0, 0, 0}, 32'h80000000, 0,
      '{0, 0, 0}, 0, ST_OK},
    '{OP_DOT, '{32'h80000000, 32'h80000000, 32'h80000000},
      '{32'h80000000, 32'h80000000, 32'h80000000}, 0, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_DOT, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
      '{32'h80000000, 32'h80000000, 32'h80000000}, 0, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_CROSS, '{32'h80000000, 32'h7fffffff, 32'h80000000},
      '{32'h7fffffff, 32'h80000000, 32'h7fffffff}, 0, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_PROD, '{32'h7fffffff, 32'h80000000, 32'h12345678},
      '{32'h7fffffff, 32'h80000000, 32'hffff0000}, 0, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_NORM, '{32'h80000000, 32'h80000000, 32'h80000000}, '{0, 0, 0}, 0, 0,
      '{0, 0, 0}, 0, ST_OK},
    '{OP_NORM, '{32'h7fffffff, 0, -1}, '{0, 0, 0}, 0, 0, '{0, 0, 0}, 0, ST_OK},
    '{OP_LEN, '{32'h80000000, 32'h80000000, 32'h80000000}, '{0, 0, 0}, 0, 0,
      '{0, 0, 0}, 0, ST_OK}
  };

  function automatic logic [63:0] magnitude(word_t v);
    return v < 0 ? 64'(-longint'(v)) : 64'(longint'(v));
  endfunction

  function automatic clamp_t clamp(logic neg, logic [63:0] mag);
    clamp_t c;
    c.sat = 1'b0;
    if (!neg && mag > 64'h7fffffff) begin
      mag = 64'h7fffffff;
      c.sat = 1'b1;
    end
    if (neg && mag > 64'h80000000) begin
      mag = 64'h80000000;
      c.sat = 1'b1;
    end
    c.val = neg ? 32'(64'd0 - mag) : mag[31:0];
    return c;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic clamp_t signed_sum(logic signed [65:0] acc, int shift);
    logic neg;
    logic [65:0] mag;
    neg = acc < 0;
    mag = neg ? 66'(-acc) : 66'(acc);
    return clamp(neg, 64'(mag >> shift));
  endfunction

  function automatic vec_result_t vector_alu(vec_item_t it);
    vec_result_t res;
    clamp_t c;
    logic sat;
    logic [63:0] q, sq, root;
    logic signed [65:0] acc;
    logic signed [64:0] t;
    int j, k;
    sat = 0;
    res.r = '{0, 0, 0};
    res.eq = 0;
    res.st = ST_OK;
    sq = magnitude(it.a[0]) * magnitude(it.a[0]) + magnitude(it.a[1]) * magnitude(it.a[1])
       + magnitude(it.a[2]) * magnitude(it.a[2]);
    root = int_sqrt(sq);
    case (it.op)
      OP_ADD, OP_SUB: for (int i = 0; i < 3; i++) begin
        t = it.op == OP_ADD ? 65'(it.a[i]) + 65'(it.b[i]) : 65'(it.a[i]) - 65'(it.b[i]);
        c = signed_sum(66'(t), 0);
        sat |= c.sat;
        res.r[i] = c.val;
      end
      OP_SCALE, OP_PROD: for (int i = 0; i < 3; i++) begin
        word_t f;
        f = it.op == OP_SCALE ? it.s : it.b[i];
        c = clamp((it.a[i] < 0) != (f < 0), (magnitude(it.a[i]) * magnitude(f)) >> 16);
        sat |= c.sat;
        res.r[i] = c.val;
      end
      OP_DIV: for (int i = 0; i < 3; i++) begin
        if (it.s == 0) begin
          if (it.a[i] != 0) res.r[i] = it.a[i] < 0 ? 32'h80000000 : 32'h7fffffff;
        end else begin
          q = (magnitude(it.a[i]) << 16) / magnitude(it.s);
          c = clamp(it.a[i] < 0, q);
          sat |= c.sat;
          if (it.s < 0) begin
            c = clamp(!(it.a[i] < 0), q);
            sat |= c.sat;
          end
          res.r[i] = c.val;
        end
      end
      OP_DOT: begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += 66'(longint'(it.a[i]) * longint'(it.b[i]));
        c = signed_sum(acc, 16);
        sat = c.sat;
        res.r[0] = c.val;
      end
      OP_CROSS: for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        acc = 66'(longint'(it.a[j]) * longint'(it.b[k]))
            - 66'(longint'(it.a[k]) * longint'(it.b[j]));
        c = signed_sum(acc, 16);
        sat |= c.sat;
        res.r[i] = c.val;
      end
      OP_NORM: for (int i = 0; i < 3; i++) begin
        if (root == 0) begin
          res.r[i] = it.a[i];
        end else begin
          c = clamp(it.a[i] < 0, (magnitude(it.a[i]) << 16) / root);
          sat |= c.sat;
          res.r[i] = c.val;
        end
      end
      OP_LEN: begin
        c = clamp(0, root);
        sat = c.sat;
        res.r[0] = c.val;
      end
      OP_LENSQ: begin
        c = clamp(0, sq >> 16);
        sat = c.sat;
        res.r[0] = c.val;
      end
      OP_EQ: res.eq = it.a == it.b;
      default: ;
    endcase
    if (it.op == OP_DIV && it.s == 0) res.st = ST_DIV0;
    else if (sat) res.st = ST_SAT;
    return res;
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
      4: return $signed($urandom_range(0, 64)) - 32 <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_item_t random_item();
    vec_item_t it;
    it.op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    foreach (it.a[i]) it.a[i] = random_word();
    if (it.op == OP_EQ && $urandom_range(0, 1)) begin
      it.b = it.a;
      if ($urandom_range(0, 1)) it.b[$urandom_range(0, 2)] ^= 32'(1) << $urandom_range(0, 31);
    end else begin
      foreach (it.b[i]) it.b[i] = random_word();
    end
    it.s = random_word();
    return it;
  endfunction

  task automatic send_beat(vec_item_t it, bit known, vec_result_t typed);
    item_valid <= 1;
    op <= it.op;
    ax <= it.a[0];
    ay <= it.a[1];
    az <= it.a[2];
    bx <= it.b[0];
    by <= it.b[1];
    bz <= it.b[2];
    scalar <= it.s;
    @(negedge clk);
    while (!item_ready) @(negedge clk);
    expected_results.push_back(known ? typed : vector_alu(it));
    @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  always begin
    clk = 1;
    #5;
    clk = 0;
    #5;
  end

  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    result_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      result_ready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("Result beat with no expectation: rx=%h", rx);
        errors++;
      end else begin
        vec_result_t e;
        e = expected_results.pop_front();
        if (rx !== e.r[0]) begin
          $error("rx: expected %h, got %h", e.r[0], rx);
          errors++;
        end
        if (ry !== e.r[1]) begin
          $error("ry: expected %h, got %h", e.r[1], ry);
          errors++;
        end
        if (rz !== e.r[2]) begin
          $error("rz: expected %h, got %h", e.r[2], rz);
          errors++;
        end
        if (is_equal !== e.eq) begin
          $error("is_equal: expected %b, got %b", e.eq, is_equal);
          errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  initial begin
    vec_item_t it;
    vec_result_t typed;
    rst <= 1;
    item_valid <= 0;
    op <= OP_ADD;
    {ax, ay, az, bx, by, bz, scalar} <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[n]) begin
      it.op = directed[n].op;
      it.a = directed[n].a;
      it.b = directed[n].b;
      it.s = directed[n].s;
      typed.r = directed[n].r;
      typed.eq = directed[n].eq;
      typed.st = directed[n].st;
      send_beat(it, directed[n].known, typed);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        item_valid <= 0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      if (n == NUM_RANDOM - QUIET_TAIL) quiet = 1;
      send_beat(random_item(), 0, typed);
    end
    item_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
